// ----- design/pal_pkg.sv -----
package pal_pkg;

    // Fixed field widths of the request and result words.
    localparam int OP_BITS    = 3;
    localparam int POS_BITS   = 5;
    localparam int VALUE_BITS = 32;
    localparam int DOUT_BITS  = 32;
    localparam int COUNT_BITS = 6;

    // Request operation codes.
    localparam logic [OP_BITS-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_DELETE    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_READ      = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REPLACE   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_WALK_FWD  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_WALK_BACK = 3'd5;
    localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd6;

    // Command broadcast to every cell of the row. At most one flag is set.
    typedef struct packed {
        logic ins;   // open a slot at the address, shift higher cells up
        logic del;   // close the slot at the address, shift higher cells down
        logic rep;   // overwrite the cell at the address
    } t_cell_op;

endpackage

// ----- design/pal_cell.sv -----
module pal_cell
    import pal_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int IDX_BITS  = 5,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  t_cell_op             i_op,
    input  logic [IDX_BITS-1:0]  i_addr,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_word,
    output logic [WORD_BITS-1:0] o_tap
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 hit;
    logic                 above;

    assign hit   = (i_addr == IDX_BITS'(IDX));
    assign above = (i_addr < IDX_BITS'(IDX));

    // Each cell only looks at its two neighbors and the broadcast command.
    always_comb begin
        n_word = r_word;
        if (i_op.ins) begin
            if (above) begin
                n_word = i_left;
            end else if (hit) begin
                n_word = i_value;
            end
        end else if (i_op.del) begin
            if (above || hit) begin
                n_word = i_right;
            end
        end else if (i_op.rep && hit) begin
            n_word = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = hit ? r_word : '0;

endmodule

// ----- design/pal_row.sv -----
module pal_row
    import pal_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32,
    parameter int IDX_BITS  = 5
) (
    input  logic                 i_clk,
    input  t_cell_op             i_op,
    input  logic [IDX_BITS-1:0]  i_addr,
    input  logic [WORD_BITS-1:0] i_value,
    output logic [WORD_BITS-1:0] o_read
);

    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic [WORD_BITS-1:0] w_tap  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = w_word[g+1];
        end

        pal_cell #(
            .IDX       (g),
            .IDX_BITS  (IDX_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_addr  (i_addr),
            .i_value (i_value),
            .i_left  (left),
            .i_right (right),
            .o_word  (w_word[g]),
            .o_tap   (w_tap[g])
        );
    end

    // Only the addressed cell drives a nonzero tap, so an OR merges them.
    always_comb begin
        o_read = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_read = o_read | w_tap[k];
        end
    end

endmodule

// ----- design/positional_array_list.sv -----
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_operation, i_position, i_value
// result    out        o_out_valid / i_out_stall  o_data_out, o_ok, o_count,
//                                                 o_is_full, o_is_empty, o_last
//
// Insert, delete, read, replace, clear and bad requests can be accepted back to back
// while no result word is stalled; the row of cells shifts every entry at once.
// A walk of N entries gives N result words, read one at a time through the single
// read port of the row; the request side stalls meanwhile.
// Reset (synchronous, active low) empties the list; cell contents are not cleared.
// A stalled result word holds, and the request side stalls until it is taken.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_BITS-1:0]    i_operation,
    input  logic [POS_BITS-1:0]   i_position,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DOUT_BITS-1:0]  o_data_out,
    output logic                  o_ok,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_is_full,
    output logic                  o_is_empty,
    output logic                  o_last
);

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    // Fill count, walk sequencer and output register.
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic                 r_walking;
    logic                 n_walking;
    logic                 r_walk_back;
    logic                 n_walk_back;
    logic [CNT_BITS-1:0]  r_walk_k;
    logic [CNT_BITS-1:0]  n_walk_k;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 r_ok;
    logic                 n_ok;
    logic                 r_last;
    logic                 n_last;

    logic                 slot_free;
    logic                 accept;
    logic [CMP_BITS-1:0]  pos_c;
    logic [CMP_BITS-1:0]  cnt_c;
    logic                 in_range;
    logic                 full;
    logic                 walk_end;
    logic [CNT_BITS-1:0]  walk_pos;
    logic [IDX_BITS-1:0]  addr;
    t_cell_op             cell_op;
    logic [WORD_BITS-1:0] read_word;

    // The result register can take a new word when empty or being drained.
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_walking || !slot_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign pos_c    = CMP_BITS'(i_position);
    assign cnt_c    = CMP_BITS'(r_count);
    assign in_range = (pos_c < cnt_c);
    assign full     = (r_count == CNT_BITS'(DEPTH));

    // A walk runs its index from the front, or mirrored from the back.
    assign walk_end = (r_walk_k == r_count - CNT_BITS'(1));
    assign walk_pos = r_walk_back ? (r_count - CNT_BITS'(1) - r_walk_k) : r_walk_k;
    assign addr     = r_walking ? IDX_BITS'(walk_pos) : IDX_BITS'(i_position);

    pal_row #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .IDX_BITS  (IDX_BITS)
    ) u_row (
        .i_clk   (i_clk),
        .i_op    (cell_op),
        .i_addr  (addr),
        .i_value (WORD_BITS'(i_value)),
        .o_read  (read_word)
    );

    always_comb begin
        n_count     = r_count;
        n_walking   = r_walking;
        n_walk_back = r_walk_back;
        n_walk_k    = r_walk_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_data      = r_data;
        n_ok        = r_ok;
        n_last      = r_last;
        cell_op     = '0;

        if (r_walking) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_data      = read_word;
                n_ok        = 1'b1;
                n_last      = walk_end;
                n_walk_k    = r_walk_k + CNT_BITS'(1);
                if (walk_end) begin
                    n_walking = 1'b0;
                end
            end
        end else if (accept) begin
            // Default result word: a rejected request with no data.
            n_out_valid = 1'b1;
            n_data      = '0;
            n_ok        = 1'b0;
            n_last      = 1'b1;
            case (i_operation)
                OP_INSERT: begin
                    if (!full && (pos_c <= cnt_c)) begin
                        cell_op.ins = 1'b1;
                        n_count     = r_count + CNT_BITS'(1);
                        n_ok        = 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (in_range) begin
                        cell_op.del = 1'b1;
                        n_count     = r_count - CNT_BITS'(1);
                        n_data      = read_word;
                        n_ok        = 1'b1;
                    end
                end
                OP_READ: begin
                    if (in_range) begin
                        n_data = read_word;
                        n_ok   = 1'b1;
                    end
                end
                OP_REPLACE: begin
                    if (in_range) begin
                        cell_op.rep = 1'b1;
                        n_ok        = 1'b1;
                    end
                end
                OP_WALK_FWD, OP_WALK_BACK: begin
                    // An empty list answers with one failed word; otherwise the
                    // sequencer streams the entries starting next cycle.
                    if (r_count != '0) begin
                        n_out_valid = 1'b0;
                        n_walking   = 1'b1;
                        n_walk_k    = '0;
                        n_walk_back = (i_operation == OP_WALK_BACK);
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                    n_ok    = 1'b1;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_walking   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_walking   <= n_walking;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk_back <= n_walk_back;
        r_walk_k    <= n_walk_k;
        r_data      <= n_data;
        r_ok        <= n_ok;
        r_last      <= n_last;
    end

    // The count cannot change while a result word waits: no request is taken
    // then, and a walk leaves the count alone. So the status fields of the
    // waiting word come straight from the live fill count.
    assign o_out_valid = r_out_valid;
    assign o_data_out  = DOUT_BITS'(r_data);
    assign o_ok        = r_ok;
    assign o_last      = r_last;
    assign o_count     = COUNT_BITS'(r_count);
    assign o_is_full   = full;
    assign o_is_empty  = (r_count == '0);

endmodule
